@@ rtl/core/json_string_unescape_utf8_defines.svh @@
// Assertion macros for the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`ifndef ASSERT_OFF
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/jsu_pkg.sv @@
// Types, codes and helper functions for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int MAX_RES     = 6;
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  typedef enum logic [2:0] {
    MODE_PLAIN      = 3'd0,
    MODE_ESC        = 3'd1,
    MODE_HEX        = 3'd2,
    MODE_AFTER_HIGH = 3'd3,
    MODE_HIGH_ESC   = 3'd4,
    MODE_LOW_HEX    = 3'd5,
    MODE_DONE       = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    MAIN_NONE,
    MAIN_BYTE,
    MAIN_CP,
    MAIN_STOP,
    MAIN_ERR
  } main_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] ERR_UNTERM_STR = 3'd0;
  localparam logic [2:0] ERR_CTRL_CHAR  = 3'd1;
  localparam logic [2:0] ERR_UNTERM_ESC = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd3;
  localparam logic [2:0] ERR_TRUNC_HEX  = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP    = 21'h010000;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [15:0] off;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]:               r = {1'b1, c[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      default:                     r = 5'd0;
    endcase
    return r;
  endfunction

  // {simple escape, replacement byte}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u.b   = '0;
    u.len = 3'd0;
    if (cp < 21'h80) begin
      u.b[0] = cp[7:0];
      u.len  = 3'd1;
    end else if (cp < 21'h800) begin
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
      u.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
      u.len  = 3'd3;
    end else begin
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
      u.len  = 3'd4;
    end
    return u;
  endfunction

  function automatic logic [15:0] clamp_off(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/json_string_unescape_utf8.sv @@
// JSON string body unescaper: escapes and \uXXXX to UTF-8, with end and error results.
// A request's results are worked out on acceptance and land in a six-entry result queue, visible
// on the out_ port from the next cycle, one per cycle while out_ready is high. A request with
// one result (or none) keeps the input at one byte per cycle while out_ready is high; one with
// more results holds in_ready low as the queue drains through the single output port, until
// only its last result is left. After the string-end or an error result every further request
// is taken and yields nothing until reset. err_offset counts body bytes and saturates at 65535.
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module json_string_unescape_utf8 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_at_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic [15:0]      out_err_offset,
  output logic             out_last
);

  localparam int OB = jsu_pkg::OFFSET_BITS;
  localparam int CW = jsu_pkg::CNT_W;
  localparam int NR = jsu_pkg::MAX_RES;

  jsu_pkg::mode_t  mode_r, mode_nxt;
  logic [23:0]     hex_bytes_r, hex_bytes_nxt;
  logic [1:0]      hex_count_r, hex_count_nxt;
  logic [9:0]      high_r, high_nxt;
  logic [OB-1:0]   pos_r, pos_nxt;
  logic [OB-1:0]   hex_start_r, hex_start_nxt;

  jsu_pkg::res_t   q_r   [NR];
  jsu_pkg::res_t   q_nxt [NR];
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic            in_acc, out_acc;
  logic [OB-1:0]   pos_after;
  logic            is_bslash, is_u, is_quote, is_ctrl;
  logic [8:0]      esc;
  logic            hex_full, hex_ok, v_hi, v_lo;
  logic [15:0]     hex_v;
  logic [4:0]      d3, d2, d1, d0;
  logic [20:0]     joined_cp;

  logic            pre;
  jsu_pkg::main_t  msel;
  logic [7:0]      mbyte;
  logic [20:0]     mcp;
  logic [2:0]      ecode;
  logic [OB-1:0]   eoff;

  jsu_pkg::utf8_t  menc, fenc;
  jsu_pkg::res_t   mlist [4];
  logic [2:0]      mlen;
  jsu_pkg::res_t   nlist [NR];
  logic [CW-1:0]   ncnt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = (cnt_r == '0) || ((cnt_r == CW'(1)) && out_ready);
  assign out_valid = (cnt_r != '0);

  assign out_byte       = q_r[0].data;
  assign out_kind       = q_r[0].kind;
  assign out_error_code = q_r[0].code;
  assign out_err_offset = q_r[0].off;
  assign out_last       = q_r[0].last;

  assign pos_after = (pos_r == {OB{1'b1}}) ? pos_r : pos_r + OB'(1);
  assign is_bslash = (in_byte == jsu_pkg::CH_BSLASH);
  assign is_u      = (in_byte == jsu_pkg::CH_U);
  assign is_quote  = (in_byte == jsu_pkg::CH_QUOTE);
  assign is_ctrl   = (in_byte < jsu_pkg::CH_SPACE);
  assign esc       = jsu_pkg::esc_map(in_byte);

  assign hex_full  = (hex_count_r == 2'd3);
  assign d3        = jsu_pkg::hex_digit(hex_bytes_r[23:16]);
  assign d2        = jsu_pkg::hex_digit(hex_bytes_r[15:8]);
  assign d1        = jsu_pkg::hex_digit(hex_bytes_r[7:0]);
  assign d0        = jsu_pkg::hex_digit(in_byte);
  assign hex_ok    = d3[4] && d2[4] && d1[4] && d0[4];
  assign hex_v     = {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
  assign v_hi      = (hex_v[15:10] == 6'b110110);
  assign v_lo      = (hex_v[15:10] == 6'b110111);
  assign joined_cp = jsu_pkg::CP_SUPP + {1'b0, high_r, hex_v[9:0]};

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    hex_bytes_nxt = hex_bytes_r;
    hex_count_nxt = hex_count_r;
    high_nxt      = high_r;
    pos_nxt       = pos_r;
    hex_start_nxt = hex_start_r;
    if (in_acc && mode_r != jsu_pkg::MODE_DONE) begin
      if (in_at_end) begin
        mode_nxt = jsu_pkg::MODE_DONE;
      end else begin
        pos_nxt = pos_after;
        case (mode_r)
          jsu_pkg::MODE_PLAIN, jsu_pkg::MODE_AFTER_HIGH: begin
            if (is_bslash) begin
              mode_nxt = (mode_r == jsu_pkg::MODE_AFTER_HIGH) ?
                         jsu_pkg::MODE_HIGH_ESC : jsu_pkg::MODE_ESC;
            end else if (is_quote || is_ctrl) begin
              mode_nxt = jsu_pkg::MODE_DONE;
            end else begin
              mode_nxt = jsu_pkg::MODE_PLAIN;
            end
          end
          jsu_pkg::MODE_ESC, jsu_pkg::MODE_HIGH_ESC: begin
            if (is_u) begin
              hex_count_nxt = 2'd0;
              hex_start_nxt = pos_after;
              mode_nxt = (mode_r == jsu_pkg::MODE_HIGH_ESC) ?
                         jsu_pkg::MODE_LOW_HEX : jsu_pkg::MODE_HEX;
            end else if (esc[8]) begin
              mode_nxt = jsu_pkg::MODE_PLAIN;
            end else begin
              mode_nxt = jsu_pkg::MODE_DONE;
            end
          end
          jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
            hex_bytes_nxt = {hex_bytes_r[15:0], in_byte};
            if (!hex_full) begin
              hex_count_nxt = hex_count_r + 2'd1;
            end else begin
              hex_count_nxt = 2'd0;
              if (!hex_ok) begin
                mode_nxt = jsu_pkg::MODE_DONE;
              end else if (mode_r == jsu_pkg::MODE_LOW_HEX && v_lo) begin
                mode_nxt = jsu_pkg::MODE_PLAIN;
              end else if (v_hi) begin
                high_nxt = hex_v[9:0];
                mode_nxt = jsu_pkg::MODE_AFTER_HIGH;
              end else begin
                mode_nxt = jsu_pkg::MODE_PLAIN;
              end
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
    end
  end

  // result selection
  always_comb begin
    pre   = 1'b0;
    msel  = jsu_pkg::MAIN_NONE;
    mbyte = in_byte;
    mcp   = '0;
    ecode = jsu_pkg::ERR_UNTERM_STR;
    eoff  = pos_r;
    if (in_at_end) begin
      case (mode_r)
        jsu_pkg::MODE_PLAIN: begin
          msel = jsu_pkg::MAIN_ERR;
        end
        jsu_pkg::MODE_ESC: begin
          msel  = jsu_pkg::MAIN_ERR;
          ecode = jsu_pkg::ERR_UNTERM_ESC;
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
          msel  = jsu_pkg::MAIN_ERR;
          ecode = jsu_pkg::ERR_TRUNC_HEX;
          eoff  = hex_start_r;
        end
        jsu_pkg::MODE_AFTER_HIGH: begin
          pre  = 1'b1;
          msel = jsu_pkg::MAIN_ERR;
        end
        jsu_pkg::MODE_HIGH_ESC: begin
          pre   = 1'b1;
          msel  = jsu_pkg::MAIN_ERR;
          ecode = jsu_pkg::ERR_UNTERM_ESC;
        end
        default: msel = jsu_pkg::MAIN_NONE;
      endcase
    end else begin
      case (mode_r)
        jsu_pkg::MODE_PLAIN, jsu_pkg::MODE_AFTER_HIGH: begin
          if (!is_bslash) begin
            pre = (mode_r == jsu_pkg::MODE_AFTER_HIGH);
            if (is_quote) begin
              msel = jsu_pkg::MAIN_STOP;
            end else if (is_ctrl) begin
              msel  = jsu_pkg::MAIN_ERR;
              ecode = jsu_pkg::ERR_CTRL_CHAR;
            end else begin
              msel = jsu_pkg::MAIN_BYTE;
            end
          end
        end
        jsu_pkg::MODE_ESC, jsu_pkg::MODE_HIGH_ESC: begin
          if (!is_u) begin
            pre = (mode_r == jsu_pkg::MODE_HIGH_ESC);
            if (esc[8]) begin
              msel  = jsu_pkg::MAIN_BYTE;
              mbyte = esc[7:0];
            end else begin
              msel  = jsu_pkg::MAIN_ERR;
              ecode = jsu_pkg::ERR_UNKNOWN;
              eoff  = pos_after;
            end
          end
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
          if (hex_full) begin
            if (!hex_ok) begin
              msel  = jsu_pkg::MAIN_ERR;
              ecode = jsu_pkg::ERR_BAD_HEX;
              eoff  = hex_start_r;
            end else if (mode_r == jsu_pkg::MODE_LOW_HEX && v_lo) begin
              msel = jsu_pkg::MAIN_CP;
              mcp  = joined_cp;
            end else begin
              pre = (mode_r == jsu_pkg::MODE_LOW_HEX);
              if (!v_hi) begin
                msel = jsu_pkg::MAIN_CP;
                mcp  = v_lo ? jsu_pkg::CP_REPLACE : {5'd0, hex_v};
              end
            end
          end
        end
        default: msel = jsu_pkg::MAIN_NONE;
      endcase
    end
  end

  assign menc = jsu_pkg::utf8_enc(mcp);
  assign fenc = jsu_pkg::utf8_enc(jsu_pkg::CP_REPLACE);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mlist[k] = '{data: menc.b[k], kind: jsu_pkg::KIND_DATA, code: 3'd0, off: 16'd0,
                   last: 1'b0};
    end
    mlen = 3'd1;
    case (msel)
      jsu_pkg::MAIN_NONE: mlen = 3'd0;
      jsu_pkg::MAIN_BYTE: mlist[0].data = mbyte;
      jsu_pkg::MAIN_CP:   mlen = menc.len;
      jsu_pkg::MAIN_STOP: begin
        mlist[0].data = 8'd0;
        mlist[0].kind = jsu_pkg::KIND_QUOTE;
      end
      jsu_pkg::MAIN_ERR: begin
        mlist[0].data = 8'd0;
        mlist[0].kind = jsu_pkg::KIND_ERR;
        mlist[0].code = ecode;
        mlist[0].off  = jsu_pkg::clamp_off(eoff);
      end
      default: mlen = 3'd0;
    endcase
  end

  // replacement char bytes first, then the main results
  always_comb begin
    logic [2:0] j;
    ncnt = CW'(mlen) + (pre ? CW'(3) : CW'(0));
    for (int i = 0; i < NR; i++) begin
      j = pre ? 3'(i - 3) : 3'(i);
      nlist[i] = mlist[0];
      if (pre && i < 3) begin
        nlist[i] = '{data: fenc.b[i], kind: jsu_pkg::KIND_DATA, code: 3'd0, off: 16'd0,
                     last: 1'b0};
      end else if (j < 3'd4) begin
        nlist[i] = mlist[j[1:0]];
      end
      nlist[i].last = (CW'(i + 1) == ncnt);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < NR; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (in_acc) begin
      cnt_nxt = (mode_r == jsu_pkg::MODE_DONE) ? '0 : ncnt;
      for (int i = 0; i < NR; i++) begin
        q_nxt[i] = nlist[i];
      end
    end else if (out_acc) begin
      cnt_nxt = cnt_r - CW'(1);
      for (int i = 0; i < NR - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= jsu_pkg::MODE_PLAIN;
      hex_count_r <= 2'd0;
      pos_r       <= '0;
      hex_start_r <= '0;
      cnt_r       <= '0;
    end else begin
      mode_r      <= mode_nxt;
      hex_count_r <= hex_count_nxt;
      pos_r       <= pos_nxt;
      hex_start_r <= hex_start_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_bytes_r <= hex_bytes_nxt;
    high_r      <= high_nxt;
    for (int i = 0; i < NR; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `JSU_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(NR))
  `JSU_ASSERT_IMPL(a_term_last, clk, rst_n, out_valid && out_kind != jsu_pkg::KIND_DATA, out_last)
  `JSU_ASSERT_NEXT(a_done_sticks, clk, rst_n, mode_r == jsu_pkg::MODE_DONE, mode_r == jsu_pkg::MODE_DONE)
  `JSU_ASSERT_NEXT(a_done_silent, clk, rst_n, in_acc && mode_r == jsu_pkg::MODE_DONE, cnt_r == '0)

endmodule
`default_nettype wire

@@ tb/unescape_check_pkg.sv @@
// Scoreboard class for the JSON string unescaper: decodes accepted requests and checks results.
`timescale 1ns / 100ps
package unescape_check_pkg;
  import jsu_pkg::*;

  localparam logic [2:0]  CODE_NONE    = 3'd0;
  localparam int unsigned POS_MAX      = 32'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam int unsigned REPORT_LIMIT = 10;

  class unescape_board;
    mode_t       mode;
    logic [31:0] hex_bytes;
    int unsigned hex_count;
    logic [9:0]  high_half;
    int unsigned body_pos;
    int unsigned hex_start;
    res_t        step_res[$];
    res_t        decoded_due[$];
    int unsigned faults;
    int unsigned checked;
    int unsigned ignored;
    int unsigned pairs_joined;
    int unsigned replacements;
    logic [1:0]  close_kind;
    logic [2:0]  close_code;
    logic [15:0] close_off;

    function new();
      mode         = MODE_PLAIN;
      hex_bytes    = '0;
      hex_count    = 0;
      high_half    = '0;
      body_pos     = 0;
      hex_start    = 0;
      faults       = 0;
      checked      = 0;
      ignored      = 0;
      pairs_joined = 0;
      replacements = 0;
      close_kind   = KIND_DATA;
      close_code   = CODE_NONE;
      close_off    = '0;
    endfunction

    function void emit(logic [7:0] b, logic [1:0] k, logic [2:0] c, int unsigned off);
      res_t r;
      if (step_res.size() >= MAX_RES) return;
      r.data = b;
      r.kind = k;
      r.code = c;
      r.off  = (off > 32'hFFFF) ? 16'hFFFF : off[15:0];
      r.last = 1'b0;
      step_res.insert(step_res.size(), r);
      if (k != KIND_DATA) begin
        close_kind = k;
        close_code = c;
        close_off  = r.off;
      end
    endfunction

    function void data_byte(logic [31:0] v);
      emit(8'(v), KIND_DATA, CODE_NONE, 0);
    endfunction

    function void stop(logic [2:0] c, int unsigned off);
      emit(8'h00, KIND_ERR, c, off);
      mode = MODE_DONE;
    endfunction

    function void put_cp(logic [31:0] cp);
      if (cp == 32'hFFFD) replacements++;
      if (cp < 32'h80) begin
        data_byte(cp);
      end else if (cp < 32'h800) begin
        data_byte(32'hC0 | (cp >> 6));
        data_byte(32'h80 | (cp & 32'h3F));
      end else if (cp < 32'h10000) begin
        data_byte(32'hE0 | (cp >> 12));
        data_byte(32'h80 | ((cp >> 6) & 32'h3F));
        data_byte(32'h80 | (cp & 32'h3F));
      end else begin
        data_byte(32'hF0 | ((cp >> 18) & 32'h07));
        data_byte(32'h80 | ((cp >> 12) & 32'h3F));
        data_byte(32'h80 | ((cp >> 6) & 32'h3F));
        data_byte(32'h80 | (cp & 32'h3F));
      end
    endfunction

    function bit hex_word(logic [31:0] bytes, output logic [15:0] v);
      logic [7:0] c;
      logic [3:0] d;
      v = '0;
      for (int i = 3; i >= 0; i--) begin
        c = bytes[8*i +: 8];
        if (c >= "0" && c <= "9") d = 4'(c - "0");
        else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
        else return 1'b0;
        v = {v[11:0], d};
      end
      return 1'b1;
    endfunction

    function void fresh_code(logic [15:0] v);
      if (v >= 16'hD800 && v <= 16'hDBFF) begin
        high_half = 10'(v - 16'hD800);
        mode      = MODE_AFTER_HIGH;
        return;
      end
      put_cp((v >= 16'hDC00 && v <= 16'hDFFF) ? 32'hFFFD : 32'(v));
      mode = MODE_PLAIN;
    endfunction

    function void plain_char(logic [7:0] b, int unsigned here);
      if (b == CH_QUOTE) begin
        emit(8'h00, KIND_QUOTE, CODE_NONE, 0);
        mode = MODE_DONE;
      end else if (b < CH_SPACE) begin
        stop(ERR_CTRL_CHAR, here);
      end else if (b == CH_BSLASH) begin
        mode = MODE_ESC;
      end else begin
        data_byte(32'(b));
        mode = MODE_PLAIN;
      end
    endfunction

    function void escape_char(logic [7:0] b, int unsigned after);
      logic [7:0] lit;
      case (b)
        CH_QUOTE:  lit = CH_QUOTE;
        CH_BSLASH: lit = CH_BSLASH;
        "/":       lit = "/";
        "b":       lit = 8'h08;
        "f":       lit = 8'h0C;
        "n":       lit = 8'h0A;
        "r":       lit = 8'h0D;
        "t":       lit = 8'h09;
        CH_U: begin
          hex_bytes = '0;
          hex_count = 0;
          hex_start = after;
          mode      = MODE_HEX;
          return;
        end
        default: begin
          stop(ERR_UNKNOWN, after);
          return;
        end
      endcase
      data_byte(32'(lit));
      mode = MODE_PLAIN;
    endfunction

    function void hex_char_in(logic [7:0] b);
      logic [15:0] v;
      hex_bytes = {hex_bytes[23:0], b};
      hex_count++;
      if (hex_count < 4) return;
      hex_count = 0;
      if (!hex_word(hex_bytes, v)) begin
        stop(ERR_BAD_HEX, hex_start);
        return;
      end
      if (mode == MODE_LOW_HEX) begin
        if (v >= 16'hDC00 && v <= 16'hDFFF) begin
          put_cp(32'h10000 + (32'(high_half) << 10) + 32'(v - 16'hDC00));
          pairs_joined++;
          mode = MODE_PLAIN;
          return;
        end
        put_cp(32'hFFFD);
      end
      fresh_code(v);
    endfunction

    function void decode_request(logic [7:0] b, logic at_end);
      int unsigned here;
      int unsigned after;
      res_t        r;
      step_res.delete();
      if (mode == MODE_DONE) begin
        ignored++;
        return;
      end
      here = body_pos;
      if (at_end) begin
        case (mode)
          MODE_PLAIN:             stop(ERR_UNTERM_STR, here);
          MODE_ESC:               stop(ERR_UNTERM_ESC, here);
          MODE_HEX, MODE_LOW_HEX: stop(ERR_TRUNC_HEX, hex_start);
          MODE_AFTER_HIGH: begin
            put_cp(32'hFFFD);
            stop(ERR_UNTERM_STR, here);
          end
          default: begin
            put_cp(32'hFFFD);
            stop(ERR_UNTERM_ESC, here);
          end
        endcase
      end else begin
        after    = (here >= POS_MAX) ? POS_MAX : here + 1;
        body_pos = after;
        case (mode)
          MODE_PLAIN:             plain_char(b, here);
          MODE_ESC:               escape_char(b, after);
          MODE_HEX, MODE_LOW_HEX: hex_char_in(b);
          MODE_AFTER_HIGH: begin
            if (b == CH_BSLASH) begin
              mode = MODE_HIGH_ESC;
            end else begin
              put_cp(32'hFFFD);
              plain_char(b, here);
            end
          end
          default: begin
            if (b == CH_U) begin
              hex_bytes = '0;
              hex_count = 0;
              hex_start = after;
              mode      = MODE_LOW_HEX;
            end else begin
              put_cp(32'hFFFD);
              escape_char(b, after);
            end
          end
        endcase
      end
      for (int i = 0; i < step_res.size(); i++) begin
        r      = step_res[i];
        r.last = (i == step_res.size() - 1);
        decoded_due.insert(decoded_due.size(), r);
      end
    endfunction

    function void match_result(res_t got);
      res_t want;
      checked++;
      if (decoded_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("%0t: unexpected result byte=%02h kind=%0d code=%0d off=%0d last=%0b",
                   $time, got.data, got.kind, got.code, got.off, got.last);
        return;
      end
      want = decoded_due.pop_front();
      if (got.data !== want.data || got.kind !== want.kind || got.code !== want.code ||
          got.off !== want.off || got.last !== want.last) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("%0t: result %0d expected byte=%02h kind=%0d code=%0d off=%0d last=%0b",
                   $time, checked, want.data, want.kind, want.code, want.off, want.last);
          $display("%0t: result %0d actual   byte=%02h kind=%0d code=%0d off=%0d last=%0b",
                   $time, checked, got.data, got.kind, got.code, got.off, got.last);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/tb_json_string_unescape_utf8.sv @@
// Top-level testbench for the JSON string unescaper: drives bytes, checks UTF-8 and end results.
`timescale 1ns / 100ps
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;
  import unescape_check_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_LEN      = 80;

  typedef enum int {
    CLOSE_QUOTE,
    CLOSE_END,
    CLOSE_CTRL,
    CLOSE_END_ESC,
    CLOSE_UNKNOWN,
    CLOSE_TRUNC,
    CLOSE_BAD,
    CLOSE_END_HIGH,
    CLOSE_HIGH_ESC
  } close_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_at_end = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic [2:0]  out_error_code;
  logic [15:0] out_err_offset;
  logic        out_last;

  unescape_board board;
  res_t          seen;
  int unsigned   sent_items    = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   hold_cycles   = 0;

  always #10 clk = ~clk;

  json_string_unescape_utf8 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_at_end      (in_at_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_err_offset (out_err_offset),
    .out_last       (out_last)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.decode_request(in_byte, in_at_end);
      if (out_valid && out_ready) begin
        seen.data = out_byte;
        seen.kind = out_kind;
        seen.code = out_error_code;
        seen.off  = out_err_offset;
        seen.last = out_last;
        board.match_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic offer(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_byte   <= b;
    in_at_end <= e;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.decoded_due.size() != 0);
  endtask

  function automatic logic [7:0] esc_letter(int unsigned k);
    case (k)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return "/";
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 8'd10);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'hFF, CH_SPACE)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] pick_in(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(5))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(3))
      0:       return pick_in(16'h0000, 16'h007F);
      1:       return pick_in(16'h0080, 16'h07FF);
      2:       return pick_in(16'h0800, 16'hD7FF);
      default: return pick_in(16'hE000, 16'hFFFF);
    endcase
  endfunction

  task automatic send_esc(input logic [7:0] letter);
    offer(CH_BSLASH, 1'b0);
    offer(letter, 1'b0);
  endtask

  task automatic send_u(input logic [15:0] v);
    offer(CH_BSLASH, 1'b0);
    offer(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) offer(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  task automatic send_chunk();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      offer(rand_plain(), 1'b0);
    end else if (pick < 45) begin
      send_esc(esc_letter($urandom_range(7)));
    end else if (pick < 62) begin
      send_u(rand_bmp());
    end else if (pick < 70) begin
      send_u(pick_in(16'hDC00, 16'hDFFF));
    end else begin
      send_u(pick_in(16'hD800, 16'hDBFF));
      case ($urandom_range(5))
        0, 1: send_u(pick_in(16'hDC00, 16'hDFFF));
        2:    offer(rand_plain(), 1'b0);
        3:    send_esc(esc_letter($urandom_range(7)));
        4:    send_u(rand_bmp());
        default: ;  // high half left pending for the next chunk
      endcase
    end
  endtask

  task automatic close_string();
    close_t     how;
    logic [7:0] b;
    int         bad_at;
    how = close_t'($urandom_range(CLOSE_HIGH_ESC));
    case (how)
      CLOSE_QUOTE: offer(CH_QUOTE, 1'b0);
      CLOSE_END:   offer(8'($urandom), 1'b1);
      CLOSE_CTRL:  offer(8'($urandom_range(CH_SPACE - 8'd1)), 1'b0);
      CLOSE_END_ESC: begin
        offer(CH_BSLASH, 1'b0);
        offer(8'($urandom), 1'b1);
      end
      CLOSE_UNKNOWN: begin
        do b = 8'($urandom);
        while (b == CH_U || b == CH_QUOTE || b == CH_BSLASH || b == "/" || b == "b" ||
               b == "f" || b == "n" || b == "r" || b == "t");
        send_esc(b);
      end
      CLOSE_TRUNC, CLOSE_BAD: begin
        if ($urandom_range(1)) send_u(pick_in(16'hD800, 16'hDBFF));
        offer(CH_BSLASH, 1'b0);
        offer(CH_U, 1'b0);
        if (how == CLOSE_TRUNC) begin
          repeat ($urandom_range(3)) offer(8'($urandom), 1'b0);
          offer(8'($urandom), 1'b1);
        end else begin
          bad_at = $urandom_range(3);
          for (int i = 0; i < 4; i++) begin
            if (i == bad_at) begin
              do b = 8'($urandom);
              while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                     (b >= "A" && b <= "F"));
            end else begin
              b = hex_char(4'($urandom));
            end
            offer(b, 1'b0);
          end
        end
      end
      CLOSE_END_HIGH: begin
        send_u(pick_in(16'hD800, 16'hDBFF));
        offer(8'($urandom), 1'b1);
      end
      default: begin
        send_u(pick_in(16'hD800, 16'hDBFF));
        offer(CH_BSLASH, 1'b0);
        offer(8'($urandom), 1'b1);
      end
    endcase
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    offer(CH_SPACE, 1'b0);
    offer(8'hFF, 1'b0);
    for (int k = 0; k < 8; k++) send_esc(esc_letter(k));
    send_u(16'h00E9);
    drain();

    send_idle_pct = 7;
    recv_idle_pct = 86;
    while (sent_items < 100) send_chunk();
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 7;
    while (sent_items < 170) send_chunk();
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = HOLD_LEN;
    repeat (16) offer(rand_plain(), 1'b0);
    while (sent_items < 230) send_chunk();

    close_string();
    repeat (6) offer(8'($urandom), 1'($urandom_range(1)));
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d after close), %0d results, %0d pairs, %0d U+FFFD",
             sent_items, board.ignored, board.checked, board.pairs_joined, board.replacements);
    $display("Stream closed with kind %0d, code %0d, offset %0d; %0d faults",
             board.close_kind, board.close_code, board.close_off, board.faults);
    if (board.faults == 0 && board.decoded_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/json_string_unescape_utf8.sv
tb/unescape_check_pkg.sv
tb/tb_json_string_unescape_utf8.sv
